[sv/pfsba_pkg.sv]
// Shared definitions for the per-frame slot bump allocator.
// Holds widths, codes, state and command/status types; no dependencies.
`default_nettype none

package pfsba_pkg;

   // Table size and derived widths.
   localparam int SLOT_COUNT = 16;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

   // Field widths.
   localparam int COUNT_W    = 16;
   localparam int FORMAT_W   = 8;
   localparam int CAP_W      = 17;
   localparam int SLOT_OUT_W = 4;
   localparam int GRAN_W     = 16;
   localparam int ENTRY_W    = FORMAT_W + 2 * CAP_W;
   localparam int DIV_CNT_W  = $clog2(CAP_W + 1);

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_GRANULARITY = '0;
   localparam logic [GRAN_W-1:0]    GRAN_RESET          = GRAN_W'(64);

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FRAME = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      RES_EMPTY,
      RES_FOUND,
      RES_APPEND,
      RES_FULL
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_APPEND,
      ST_REFILL_RD,
      ST_REFILL_WR
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clr_idx;
      logic       inc_idx;
      logic       wr_refill;
      logic       emit;
      result_type result;
   } cmd_type;

   typedef struct packed {
      logic is_frame;
      logic is_zero;
      logic idx_at_end;
      logic match;
      logic table_full;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

[sv/per_frame_slot_bump_allocator.sv]
// Top level of the per-frame slot bump allocator: register port and glue.
// Uses pfsba_pkg, pfsba_ctrl and pfsba_dp.
`default_nettype none

// Usage.
// A word is taken on req_* when start is high and busy is low. An allocate
// word (kind 0) gives one result word on rsp_*, marked by rsp_valid for
// exactly one cycle; a frame word (kind 1) refills every used slot and
// gives no result. The receiver cannot hold results off.
// A scan reads the slot table once per slot, a registered RAM read and
// then a compare for each slot. A miss with room in the table waits
// also for the rounding divider, started when the word is taken. A
// frame word keeps busy high while it refills the used slots. Busy
// falls as the result is shown, so the next word may be taken while it
// is on the ports.
// Reset empties the slot table (no clearing pass) and sets the
// granularity register (address 0) to 64.
module per_frame_slot_bump_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_kind,
   input  wire logic [pfsba_pkg::COUNT_W-1:0]     req_request_count,
   input  wire logic [pfsba_pkg::FORMAT_W-1:0]    req_format_id,
   output logic                                   rsp_valid,
   output logic                                   rsp_ok,
   output logic                                   rsp_empty_range,
   output logic      [pfsba_pkg::SLOT_OUT_W-1:0]  rsp_slot_index,
   output logic      [pfsba_pkg::CAP_W-1:0]       rsp_first_vertex,
   output logic      [pfsba_pkg::COUNT_W-1:0]     rsp_range_length,
   output logic                                   rsp_new_slot,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pfsba_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [pfsba_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [pfsba_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                   pready
);
   import pfsba_pkg::*;

   logic [GRAN_W-1:0]    gran_ff, gran_in;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_write;
   cmd_type              cmd;
   status_type           status;

   // Register port: one granularity register, writes complete at once.
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      gran_in = gran_ff;
      if (csr_write && (csr_index == CSR_REG_GRANULARITY)) begin
         gran_in = pwdata[GRAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gran_ff <= GRAN_RESET;
      end else begin
         gran_ff <= gran_in;
      end
   end

   assign prdata = (csr_index == CSR_REG_GRANULARITY) ?
                   {{(CSR_DATA_W - GRAN_W){1'b0}}, gran_ff} : '0;

   pfsba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   pfsba_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .granularity       (gran_ff),
      .req_kind          (req_kind),
      .req_request_count (req_request_count),
      .req_format_id     (req_format_id),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_empty_range   (rsp_empty_range),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_first_vertex  (rsp_first_vertex),
      .rsp_range_length  (rsp_range_length),
      .rsp_new_slot      (rsp_new_slot)
   );

endmodule

`default_nettype wire

[sv/pfsba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfsba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[sv/pfsba_round.sv]
// Iterative unit that rounds a count up to a multiple of the granularity.
// One remainder bit per cycle; uses pfsba_pkg.
`default_nettype none

module pfsba_round (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pfsba_pkg::COUNT_W-1:0] count,
   input  wire logic [pfsba_pkg::GRAN_W-1:0]  granularity,
   output logic                               done,
   output logic      [pfsba_pkg::CAP_W-1:0]   capacity
);
   import pfsba_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [CAP_W-1:0]     n_ff, n_in;
   logic [CAP_W-1:0]     shift_ff, shift_in;
   logic [GRAN_W-1:0]    rem_ff, rem_in;
   logic [GRAN_W-1:0]    divisor_ff, divisor_in;
   logic [GRAN_W-1:0]    gran_eff;
   logic [CAP_W-1:0]     rem_shift;

   // A granularity of zero behaves as one.
   assign gran_eff  = (granularity == '0) ? GRAN_W'(1) : granularity;
   assign rem_shift = {rem_ff, shift_ff[CAP_W-1]};

   // Restoring division of count + g - 1 by g; only the remainder is kept.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      step_in    = step_ff;
      n_in       = n_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         step_in    = DIV_CNT_W'(CAP_W);
         n_in       = {1'b0, count} + {1'b0, gran_eff} - CAP_W'(1);
         shift_in   = {1'b0, count} + {1'b0, gran_eff} - CAP_W'(1);
         rem_in     = '0;
         divisor_in = gran_eff;
      end else if (busy_ff) begin
         shift_in = {shift_ff[CAP_W-2:0], 1'b0};
         if (rem_shift >= {1'b0, divisor_ff}) begin
            rem_in = GRAN_W'(rem_shift - {1'b0, divisor_ff});
         end else begin
            rem_in = GRAN_W'(rem_shift);
         end
         step_in = step_ff - DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      n_ff       <= n_in;
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   // Rounded value is the dividend less its remainder.
   assign done     = done_ff;
   assign capacity = n_ff - {1'b0, rem_ff};

endmodule

`default_nettype wire

[sv/pfsba_dp.sv]
// Datapath of the allocator: request latch, slot table, scan index,
// rounding unit and result word. Uses pfsba_pkg, pfsba_ram, pfsba_round.
`default_nettype none

module pfsba_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire pfsba_pkg::cmd_type               cmd,
   output pfsba_pkg::status_type                 status,
   input  wire logic [pfsba_pkg::GRAN_W-1:0]     granularity,
   input  wire logic                             req_kind,
   input  wire logic [pfsba_pkg::COUNT_W-1:0]    req_request_count,
   input  wire logic [pfsba_pkg::FORMAT_W-1:0]   req_format_id,
   output logic                                  rsp_valid,
   output logic                                  rsp_ok,
   output logic                                  rsp_empty_range,
   output logic      [pfsba_pkg::SLOT_OUT_W-1:0] rsp_slot_index,
   output logic      [pfsba_pkg::CAP_W-1:0]      rsp_first_vertex,
   output logic      [pfsba_pkg::COUNT_W-1:0]    rsp_range_length,
   output logic                                  rsp_new_slot
);
   import pfsba_pkg::*;

   logic                  kind_ff, kind_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [FORMAT_W-1:0]   format_ff, format_in;
   logic [SLOT_CNT_W-1:0] idx_ff, idx_in;
   logic [SLOT_CNT_W-1:0] used_ff, used_in;

   logic                  valid_ff, valid_in;
   logic                  ok_ff, ok_in;
   logic                  empty_ff, empty_in;
   logic [SLOT_OUT_W-1:0] slot_ff, slot_in;
   logic [CAP_W-1:0]      first_ff, first_in;
   logic [COUNT_W-1:0]    length_ff, length_in;
   logic                  new_ff, new_in;

   logic [ENTRY_W-1:0]    rd_entry;
   logic [FORMAT_W-1:0]   rd_format;
   logic [CAP_W-1:0]      rd_cap;
   logic [CAP_W-1:0]      rd_rem;
   logic [CAP_W-1:0]      count_wide;
   logic                  we;
   logic [SLOT_IDX_W-1:0] waddr;
   logic [ENTRY_W-1:0]    wdata;
   logic                  div_done;
   logic [CAP_W-1:0]      new_cap;
   logic                  take_found;
   logic                  take_append;

   // Slot table: format, capacity and remaining count in one entry.
   pfsba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (idx_ff[SLOT_IDX_W-1:0]),
      .rdata (rd_entry)
   );

   // Capacity of a new slot, started as soon as the word is taken.
   pfsba_round u_round (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.load),
      .count       (req_request_count),
      .granularity (granularity),
      .done        (div_done),
      .capacity    (new_cap)
   );

   assign rd_format  = rd_entry[ENTRY_W-1 -: FORMAT_W];
   assign rd_cap     = rd_entry[2*CAP_W-1 -: CAP_W];
   assign rd_rem     = rd_entry[CAP_W-1:0];
   assign count_wide = {1'b0, count_ff};

   assign take_found  = cmd.emit && (cmd.result == RES_FOUND);
   assign take_append = cmd.emit && (cmd.result == RES_APPEND);

   // Table write: refill, bump of a matching slot, or append of a new slot.
   always_comb begin
      we    = cmd.wr_refill || take_found || take_append;
      waddr = idx_ff[SLOT_IDX_W-1:0];
      wdata = {rd_format, rd_cap, rd_cap};
      if (take_append) begin
         waddr = used_ff[SLOT_IDX_W-1:0];
         wdata = {format_ff, new_cap, new_cap - count_wide};
      end else if (take_found) begin
         wdata = {rd_format, rd_cap, rd_rem - count_wide};
      end
   end

   // Request latch, scan index and fill count.
   always_comb begin
      kind_in   = kind_ff;
      count_in  = count_ff;
      format_in = format_ff;
      idx_in    = idx_ff;
      used_in   = used_ff;
      if (cmd.load) begin
         kind_in   = req_kind;
         count_in  = req_request_count;
         format_in = req_format_id;
      end
      if (cmd.clr_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_ff + SLOT_CNT_W'(1);
      end
      if (take_append) begin
         used_in = used_ff + SLOT_CNT_W'(1);
      end
   end

   // Result word, shown for one cycle.
   always_comb begin
      valid_in  = cmd.emit;
      ok_in     = ok_ff;
      empty_in  = empty_ff;
      slot_in   = slot_ff;
      first_in  = first_ff;
      length_in = length_ff;
      new_in    = new_ff;
      if (cmd.emit) begin
         ok_in     = (cmd.result != RES_FULL);
         empty_in  = (cmd.result == RES_EMPTY);
         slot_in   = '0;
         first_in  = '0;
         length_in = '0;
         new_in    = take_append;
         if (take_found) begin
            slot_in   = SLOT_OUT_W'(idx_ff[SLOT_IDX_W-1:0]);
            first_in  = rd_cap - rd_rem;
            length_in = count_ff;
         end else if (take_append) begin
            slot_in   = SLOT_OUT_W'(used_ff[SLOT_IDX_W-1:0]);
            length_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         used_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         used_ff  <= used_in;
         valid_ff <= valid_in;
      end
      kind_ff   <= kind_in;
      count_ff  <= count_in;
      format_ff <= format_in;
      ok_ff     <= ok_in;
      empty_ff  <= empty_in;
      slot_ff   <= slot_in;
      first_ff  <= first_in;
      length_ff <= length_in;
      new_ff    <= new_in;
   end

   // Status back to the controller.
   always_comb begin
      status.is_frame   = (kind_ff == KIND_FRAME);
      status.is_zero    = (count_ff == '0);
      status.idx_at_end = (idx_ff == used_ff);
      status.match      = (rd_format == format_ff) && (rd_rem >= count_wide);
      status.table_full = (used_ff == SLOT_CNT_W'(SLOT_COUNT));
      status.div_done   = div_done;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_ok           = ok_ff;
   assign rsp_empty_range  = empty_ff;
   assign rsp_slot_index   = slot_ff;
   assign rsp_first_vertex = first_ff;
   assign rsp_range_length = length_ff;
   assign rsp_new_slot     = new_ff;

endmodule

`default_nettype wire

[sv/pfsba_ctrl.sv]
// Controller of the allocator: sequences dispatch, slot scan, append
// and frame refill. Uses pfsba_pkg.
`default_nettype none

module pfsba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire pfsba_pkg::status_type status,
   output pfsba_pkg::cmd_type         cmd
);
   import pfsba_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.clr_idx   = 1'b0;
      cmd.inc_idx   = 1'b0;
      cmd.wr_refill = 1'b0;
      cmd.emit      = 1'b0;
      cmd.result    = RES_EMPTY;
      busy          = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.clr_idx = 1'b1;
            priority if (status.is_frame) begin
               state_in = ST_REFILL_RD;
            end else if (status.is_zero) begin
               cmd.emit   = 1'b1;
               cmd.result = RES_EMPTY;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         // The table read issued here returns in the next state.
         ST_SCAN_RD: begin
            if (status.idx_at_end) begin
               state_in = ST_APPEND;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (status.match) begin
               cmd.emit   = 1'b1;
               cmd.result = RES_FOUND;
               state_in   = ST_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         // No slot fits: report a full table, or wait for the rounded capacity and append.
         ST_APPEND: begin
            priority if (status.table_full) begin
               cmd.emit   = 1'b1;
               cmd.result = RES_FULL;
               state_in   = ST_IDLE;
            end else if (status.div_done) begin
               cmd.emit   = 1'b1;
               cmd.result = RES_APPEND;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_REFILL_RD: begin
            if (status.idx_at_end) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_REFILL_WR;
            end
         end
         ST_REFILL_WR: begin
            cmd.wr_refill = 1'b1;
            cmd.inc_idx   = 1'b1;
            state_in      = ST_REFILL_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the per-frame slot bump allocator.
// Drives allocate and frame words and the granularity register, and checks every
// result word against its typed row or a slot-table predictor. Uses pfsba_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfsba_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_WAIT  = 40;
   localparam int PHASE_WORDS  = 190;
   localparam int PRINT_LIMIT  = 50;

   // One result word, field for field as the block shows it.
   typedef struct packed {
      logic                  ok;
      logic                  empty_range;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [CAP_W-1:0]      first_vertex;
      logic [COUNT_W-1:0]    range_length;
      logic                  new_slot;
   } alloc_result_type;

   // One row of the directed stimulus; typed rows carry their own expected word.
   typedef struct {
      kind_type             kind;
      logic [COUNT_W-1:0]   count;
      logic [FORMAT_W-1:0]  fmt;
      bit                   typed;
      alloc_result_type     want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_kind;
   logic [COUNT_W-1:0]     req_request_count;
   logic [FORMAT_W-1:0]    req_format_id;
   logic                   rsp_valid;
   logic                   rsp_ok;
   logic                   rsp_empty_range;
   logic [SLOT_OUT_W-1:0]  rsp_slot_index;
   logic [CAP_W-1:0]       rsp_first_vertex;
   logic [COUNT_W-1:0]     rsp_range_length;
   logic                   rsp_new_slot;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   // Predicted copy of the slot table and the granularity register.
   int                     pool_used;
   logic [FORMAT_W-1:0]    pool_format    [SLOT_COUNT];
   logic [CAP_W-1:0]       pool_capacity  [SLOT_COUNT];
   logic [CAP_W-1:0]       pool_remaining [SLOT_COUNT];
   logic [GRAN_W-1:0]      pool_granularity;

   alloc_result_type       pending_ranges [$];
   stim_row_type           directed_rows  [$];
   int                     mismatches;
   int                     cycle_count;

   per_frame_slot_bump_allocator u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_request_count (req_request_count),
      .req_format_id     (req_format_id),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_empty_range   (rsp_empty_range),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_first_vertex  (rsp_first_vertex),
      .rsp_range_length  (rsp_range_length),
      .rsp_new_slot      (rsp_new_slot),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Works out the word an input causes and updates the predicted table.
   // Returns 0 for a frame word, which gives no result.
   function automatic bit predict_pool_alloc(input kind_type kind,
                                             input logic [COUNT_W-1:0] count,
                                             input logic [FORMAT_W-1:0] fmt,
                                             output alloc_result_type res);
      int          hit;
      int unsigned step;
      int unsigned cap;
      res = '0;
      res.ok = 1'b1;
      hit = -1;
      // A frame boundary refills every slot in use.
      if (kind == KIND_FRAME) begin
         for (int i = 0; i < pool_used; i++) begin
            pool_remaining[i] = pool_capacity[i];
         end
         return 1'b0;
      end
      // A zero count gets an empty range and leaves the table alone.
      if (count == '0) begin
         res.empty_range = 1'b1;
         return 1'b1;
      end
      // First fit in table order.
      for (int i = 0; i < pool_used && hit < 0; i++) begin
         if (pool_format[i] == fmt && pool_remaining[i] >= CAP_W'(count)) begin
            hit = i;
         end
      end
      // No fit: append a slot, unless the table is already full.
      if (hit < 0) begin
         if (pool_used >= SLOT_COUNT) begin
            res.ok = 1'b0;
            return 1'b1;
         end
         step = (pool_granularity == '0) ? 1 : pool_granularity;
         cap = ((count + step - 1) / step) * step;
         hit = pool_used;
         pool_format[hit]    = fmt;
         pool_capacity[hit]  = cap[CAP_W-1:0];
         pool_remaining[hit] = cap[CAP_W-1:0];
         pool_used++;
         res.new_slot = 1'b1;
      end
      res.slot_index   = SLOT_OUT_W'(hit);
      res.first_vertex = pool_capacity[hit] - pool_remaining[hit];
      res.range_length = count;
      pool_remaining[hit] = pool_remaining[hit] - CAP_W'(count);
      return 1'b1;
   endfunction

   // A format that no slot in use carries, so that the word must append.
   function automatic logic [FORMAT_W-1:0] fresh_format();
      logic [FORMAT_W-1:0] f;
      bit                  taken;
      do begin
         f = FORMAT_W'($urandom_range(0, 255));
         taken = 1'b0;
         for (int i = 0; i < pool_used; i++) begin
            if (pool_format[i] == f) taken = 1'b1;
         end
      end while (taken);
      return f;
   endfunction

   function automatic stim_row_type make_row(input kind_type kind, input int count,
                                             input int fmt, input bit typed, input bit ok,
                                             input bit empty, input int slot, input int first,
                                             input int len, input bit appended);
      stim_row_type row;
      row.kind  = kind;
      row.count = COUNT_W'(count);
      row.fmt   = FORMAT_W'(fmt);
      row.typed = typed;
      row.want.ok           = ok;
      row.want.empty_range  = empty;
      row.want.slot_index   = SLOT_OUT_W'(slot);
      row.want.first_vertex = CAP_W'(first);
      row.want.range_length = COUNT_W'(len);
      row.want.new_slot     = appended;
      return row;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Offers one word after a gap, then waits until the block has taken it and is no longer busy.
   task automatic send_word(input kind_type kind, input logic [COUNT_W-1:0] count,
                            input logic [FORMAT_W-1:0] fmt, input int gap,
                            input bit typed, input alloc_result_type typed_res);
      alloc_result_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= kind;
      req_request_count <= count;
      req_format_id     <= fmt;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_pool_alloc(kind, count, fmt, predicted)) begin
         pending_ranges.insert(pending_ranges.size(), typed ? typed_res : predicted);
      end
   endtask

   // Holds the sender off until every expected word has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_ranges.size() != 0) @(posedge clock);
   endtask

   // Writes the granularity register while the block is idle, then reads it back.
   task automatic write_granularity(input logic [GRAN_W-1:0] value);
      drain_results();
      // A frame word gives no result, so let any refill pass finish.
      repeat (SETTLE_WAIT) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_REG_GRANULARITY, 2'b00};
      pwdata  <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      pool_granularity = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[GRAN_W-1:0] !== value) begin
         report_mismatch($sformatf("granularity read back %0d, written %0d",
                                   prdata[GRAN_W-1:0], value));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result checker: each word against the oldest expectation.
   always @(posedge clock) begin
      alloc_result_type seen;
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         seen.ok           = rsp_ok;
         seen.empty_range  = rsp_empty_range;
         seen.slot_index   = rsp_slot_index;
         seen.first_vertex = rsp_first_vertex;
         seen.range_length = rsp_range_length;
         seen.new_slot     = rsp_new_slot;
         if (pending_ranges.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = pending_ranges.pop_front();
            if (seen !== want) begin
               report_mismatch({
                  $sformatf("got ok=%0b empty=%0b slot=%0d first=%0d len=%0d new=%0b",
                            seen.ok, seen.empty_range, seen.slot_index,
                            seen.first_vertex, seen.range_length, seen.new_slot),
                  $sformatf(", want ok=%0b empty=%0b slot=%0d first=%0d len=%0d new=%0b",
                            want.ok, want.empty_range, want.slot_index,
                            want.first_vertex, want.range_length, want.new_slot)});
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("per_frame_slot_bump_allocator test failed");
         $finish;
      end
   end

   initial begin
      int                  gran_values [7];
      bit                  burst;
      kind_type            kind;
      logic [COUNT_W-1:0]  count;
      logic [FORMAT_W-1:0] fmt;

      reset             = 1'b1;
      start             = 1'b0;
      req_kind          = KIND_ALLOC;
      req_request_count = '0;
      req_format_id     = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      mismatches        = 0;
      cycle_count       = 0;
      pool_used         = 0;
      pool_granularity  = GRAN_RESET;
      burst             = 1'b0;

      // Directed words from reset, granularity 64. Typed rows are read off by hand.
      add_row(make_row(KIND_ALLOC, 0, 0, 1, 1, 1, 0, 0, 0, 0));
      add_row(make_row(KIND_ALLOC, 1, 0, 1, 1, 0, 0, 0, 1, 1));
      add_row(make_row(KIND_ALLOC, 63, 0, 1, 1, 0, 0, 1, 63, 0));
      add_row(make_row(KIND_ALLOC, 1, 0, 1, 1, 0, 1, 0, 1, 1));
      add_row(make_row(KIND_ALLOC, 65535, 255, 1, 1, 0, 2, 0, 65535, 1));
      add_row(make_row(KIND_ALLOC, 1, 255, 1, 1, 0, 2, 65535, 1, 0));
      add_row(make_row(KIND_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_row(KIND_ALLOC, 65535, 255, 1, 1, 0, 2, 0, 65535, 0));
      add_row(make_row(KIND_ALLOC, 0, 255, 1, 1, 1, 0, 0, 0, 0));
      add_row(make_row(KIND_ALLOC, 64, 0, 1, 1, 0, 0, 0, 64, 0));
      add_row(make_row(KIND_ALLOC, 100, 'h5A, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_row(KIND_ALLOC, 28, 'h5A, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_row(KIND_ALLOC, 29, 'h5A, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_row(KIND_FRAME, 65535, 255, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_row(KIND_ALLOC, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_row(KIND_ALLOC, 65535, 'hA5, 0, 0, 0, 0, 0, 0, 0));

      // Granularity settings, extremes first; zero must behave as one.
      gran_values[0] = 0;
      gran_values[1] = 1;
      gran_values[2] = 65535;
      gran_values[3] = $urandom_range(1, 65535);
      gran_values[4] = $urandom_range(1, 255);
      gran_values[5] = $urandom_range(256, 65535);
      gran_values[6] = 64;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].kind, directed_rows[r].count, directed_rows[r].fmt,
                   $urandom_range(0, 3), directed_rows[r].typed, directed_rows[r].want);
      end

      // Random phases, one per granularity setting.
      foreach (gran_values[p]) begin
         write_granularity(GRAN_W'(gran_values[p]));
         // Open each phase with a word that must append under the new setting, unless the table is full.
         send_word(KIND_ALLOC, COUNT_W'($urandom_range(1, 65535)), fresh_format(),
                   $urandom_range(0, 3), 1'b0, '0);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            if (n == PHASE_WORDS / 2) drain_results();
            kind = ($urandom_range(0, 7) == 0) ? KIND_FRAME : KIND_ALLOC;
            case ($urandom_range(0, 9))
               0:       count = '0;
               1:       count = '1;
               2:       count = COUNT_W'($urandom_range(0, 65535));
               3, 4:    count = COUNT_W'($urandom_range(1, 1024));
               default: count = COUNT_W'($urandom_range(1, 64));
            endcase
            // Mostly formats already in the table, so that words hit existing slots.
            if (pool_used > 0 && $urandom_range(0, 29) != 0) begin
               fmt = pool_format[$urandom_range(0, pool_used - 1)];
            end else begin
               fmt = FORMAT_W'($urandom_range(0, 255));
            end
            send_word(kind, count, fmt, burst ? 0 : $urandom_range(0, 3), 1'b0, '0);
         end
      end

      // Fill the table, then ask four more times, each reported full; zero still wins.
      while (pool_used < SLOT_COUNT) begin
         send_word(KIND_ALLOC, COUNT_W'($urandom_range(1, 65535)), fresh_format(),
                   $urandom_range(0, 3), 1'b0, '0);
      end
      repeat (4) begin
         send_word(KIND_ALLOC, COUNT_W'($urandom_range(1, 65535)), fresh_format(),
                   $urandom_range(0, 3), 1'b0, '0);
      end
      send_word(KIND_ALLOC, '0, fresh_format(), 0, 1'b0, '0);

      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatches == 0 && pending_ranges.size() == 0) begin
         $display("per_frame_slot_bump_allocator test passed");
      end else begin
         $display("per_frame_slot_bump_allocator test failed");
      end
      $finish;
   end

endmodule
